// File: rtl/core/indexed_list_store_defines.svh
// Assertion macros shared by the indexed list store RTL.
`ifndef INDEXED_LIST_STORE_DEFINES_SVH
`define INDEXED_LIST_STORE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ILS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("indexed_list_store: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ILS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("indexed_list_store: next-cycle check failed");

`endif

// File: rtl/core/ils_pkg.sv
// Shared constants, codes and controller/datapath interface types.
package ils_pkg;

   localparam int CAPACITY = 256;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam int ACT_W   = 3;
   localparam int POS_W   = 9;
   localparam int VAL_W   = 32;
   localparam int STAT_W  = 2;
   localparam int ENTRY_W = 9;

   // Compare width: holds position, count and count + 1 without overflow.
   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   localparam int REQ_DATA_W = ((POS_W + VAL_W + 7) / 8) * 8;
   localparam int RSP_BITS   = VAL_W + 1 + STAT_W + ENTRY_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd0;
   localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd1;
   localparam logic [ACT_W-1:0] ACT_INSERT     = 3'd2;
   localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
   localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd4;
   localparam logic [ACT_W-1:0] ACT_REMOVE     = 3'd5;
   localparam logic [ACT_W-1:0] ACT_READ       = 3'd6;
   localparam logic [ACT_W-1:0] ACT_SEARCH     = 3'd7;

   localparam logic [STAT_W-1:0] STS_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STS_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] STS_FULL  = 2'd2;

   // Controller to datapath.
   typedef struct packed {
      logic accept;  // latch the request and its decoded plan
      logic rd;      // read entry at the walk pointer, advance the pointer
      logic put;     // write the new item at its slot
      logic commit;  // update count, load the response word
   } ils_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic walk;    // request needs a walk over stored entries
      logic put;     // request writes a new item after the walk
      logic last;    // walk pointer sits on the final entry
   } ils_stat_type;

endpackage

// File: rtl/core/ils_datapath.sv
// Entry memory, walk pointer, request decode and response register.
module ils_datapath import ils_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  ils_cmd_type           cmd,
   input  logic [ACT_W-1:0]      action,
   input  logic [POS_W-1:0]      position,
   input  logic [VAL_W-1:0]      item_value,
   output ils_stat_type          stat,
   output logic [RSP_DATA_W-1:0] rsp_data
);

`include "indexed_list_store_defines.svh"

   typedef enum logic [2:0] {
      OP_NONE   = 3'b000,
      OP_INSERT = 3'b001,
      OP_REMOVE = 3'b010,
      OP_READ   = 3'b011,
      OP_SEARCH = 3'b100
   } ils_op_type;

   logic [VAL_W-1:0] mem [CAPACITY];
   logic [VAL_W-1:0] rdata_ff;

   ils_op_type       op_ff, op_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic             walk_ff, walk_in;
   logic             put_ff, put_in;
   logic             up_ff, up_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic [IDX_W-1:0] end_ff, end_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] waddr_ff, waddr_in;
   logic             pend_ff, pend_in;
   logic [VAL_W-1:0] value_ff, value_in;
   logic [VAL_W-1:0] rd_ff, rd_in;
   logic             found_ff, found_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] nxt_count_ff, nxt_count_in;
   logic [RSP_DATA_W-1:0] rsp_ff, rsp_in;

   // Decode
   ils_op_type        dec_op;
   logic [STAT_W-1:0] dec_status;
   logic              dec_walk, dec_put, dec_up, dec_ins, dec_rem;
   logic [CMP_W-1:0]  pos_x, cnt_x, tgt_x, start_x, end_x;
   logic [CNT_W-1:0]  dec_count;
   logic              full, empty;

   // Write port
   logic              mem_we;
   logic [IDX_W-1:0]  mem_wa;
   logic [VAL_W-1:0]  mem_wd;

   always_comb begin
      pos_x      = CMP_W'(position);
      cnt_x      = CMP_W'(count_ff);
      full       = (cnt_x >= CMP_W'(CAPACITY));
      empty      = (count_ff == '0);
      dec_op     = OP_NONE;
      dec_status = STS_OK;
      dec_walk   = 1'b0;
      dec_put    = 1'b0;
      dec_up     = 1'b1;
      dec_ins    = 1'b0;
      dec_rem    = 1'b0;
      tgt_x      = '0;
      start_x    = '0;
      end_x      = '0;
      dec_count  = count_ff;
      case (action)
         ACT_PUSH_BACK: begin
            if (full) dec_status = STS_FULL;
            else begin dec_ins = 1'b1; tgt_x = cnt_x; end
         end
         ACT_PUSH_FRONT: begin
            if (full) dec_status = STS_FULL;
            else dec_ins = 1'b1;
         end
         ACT_INSERT: begin
            if (pos_x > cnt_x) dec_status = STS_RANGE;
            else if (full) dec_status = STS_FULL;
            else begin dec_ins = 1'b1; tgt_x = pos_x; end
         end
         ACT_POP_BACK: begin
            if (empty) dec_status = STS_RANGE;
            else begin dec_rem = 1'b1; tgt_x = cnt_x - CMP_W'(1); end
         end
         ACT_POP_FRONT: begin
            if (empty) dec_status = STS_RANGE;
            else dec_rem = 1'b1;
         end
         ACT_REMOVE: begin
            if (pos_x >= cnt_x) dec_status = STS_RANGE;
            else begin dec_rem = 1'b1; tgt_x = pos_x; end
         end
         ACT_READ: begin
            if (pos_x >= cnt_x) dec_status = STS_RANGE;
            else begin
               dec_op   = OP_READ;
               dec_walk = 1'b1;
               start_x  = pos_x;
               end_x    = pos_x;
            end
         end
         default: begin
            dec_op   = OP_SEARCH;
            dec_walk = !empty;
            end_x    = cnt_x - CMP_W'(1);
         end
      endcase
      // Insert: move entries tgt..count-1 up one slot, walking downward.
      if (dec_ins) begin
         dec_op    = OP_INSERT;
         dec_put   = 1'b1;
         dec_up    = 1'b0;
         dec_walk  = (cnt_x > tgt_x);
         start_x   = cnt_x - CMP_W'(1);
         end_x     = tgt_x;
         dec_count = count_ff + CNT_W'(1);
      end
      // Remove: move entries tgt+1..count-1 down one slot, walking upward.
      if (dec_rem) begin
         dec_op    = OP_REMOVE;
         dec_walk  = ((tgt_x + CMP_W'(1)) < cnt_x);
         start_x   = tgt_x + CMP_W'(1);
         end_x     = cnt_x - CMP_W'(1);
         dec_count = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      op_in        = op_ff;
      status_in    = status_ff;
      walk_in      = walk_ff;
      put_in       = put_ff;
      up_in        = up_ff;
      ptr_in       = ptr_ff;
      end_in       = end_ff;
      idx_in       = idx_ff;
      value_in     = value_ff;
      nxt_count_in = nxt_count_ff;
      rd_in        = rd_ff;
      found_in     = found_ff;
      count_in     = count_ff;
      rsp_in       = rsp_ff;
      pend_in      = cmd.rd;
      waddr_in     = up_ff ? (ptr_ff - IDX_W'(1)) : (ptr_ff + IDX_W'(1));

      if (cmd.accept) begin
         op_in        = dec_op;
         status_in    = dec_status;
         walk_in      = dec_walk;
         put_in       = dec_put;
         up_in        = dec_up;
         ptr_in       = start_x[IDX_W-1:0];
         end_in       = end_x[IDX_W-1:0];
         idx_in       = tgt_x[IDX_W-1:0];
         value_in     = item_value;
         nxt_count_in = dec_count;
         rd_in        = '0;
         found_in     = 1'b0;
      end

      if (cmd.rd) begin
         ptr_in = up_ff ? (ptr_ff + IDX_W'(1)) : (ptr_ff - IDX_W'(1));
      end

      // Consume the word read in the previous cycle.
      if (pend_ff) begin
         if (op_ff == OP_SEARCH && rdata_ff == value_ff) found_in = 1'b1;
         if (op_ff == OP_READ) rd_in = rdata_ff;
      end

      if (cmd.commit) begin
         count_in = nxt_count_ff;
         rsp_in   = RSP_DATA_W'({ENTRY_W'(nxt_count_ff), status_ff, found_ff, rd_ff});
      end
   end

   always_comb begin
      mem_we = 1'b0;
      mem_wa = waddr_ff;
      mem_wd = rdata_ff;
      if (pend_ff && (op_ff == OP_INSERT || op_ff == OP_REMOVE)) begin
         mem_we = 1'b1;
      end else if (cmd.put) begin
         mem_we = 1'b1;
         mem_wa = idx_ff;
         mem_wd = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (cmd.rd) rdata_ff <= mem[ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
      op_ff        <= op_in;
      status_ff    <= status_in;
      walk_ff      <= walk_in;
      put_ff       <= put_in;
      up_ff        <= up_in;
      ptr_ff       <= ptr_in;
      end_ff       <= end_in;
      idx_ff       <= idx_in;
      waddr_ff     <= waddr_in;
      value_ff     <= value_in;
      rd_ff        <= rd_in;
      found_ff     <= found_in;
      nxt_count_ff <= nxt_count_in;
      rsp_ff       <= rsp_in;
   end

   assign stat.walk = walk_ff;
   assign stat.put  = put_ff;
   assign stat.last = (ptr_ff == end_ff);
   assign rsp_data  = rsp_ff;

   `ILS_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CNT_W'(CAPACITY))
   `ILS_ASSERT_NOW(a_full_means_full, cmd.commit && status_ff == STS_FULL, count_ff == CNT_W'(CAPACITY))

endmodule

// File: rtl/core/ils_controller.sv
// Sequencer for the list store: accept, walk, drain, put and respond.
module ils_controller import ils_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  ils_stat_type stat,
   output ils_cmd_type  cmd
);

`include "indexed_list_store_defines.svh"

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_START = 6'b000010,
      ST_WALK  = 6'b000100,
      ST_DRAIN = 6'b001000,
      ST_PUT   = 6'b010000,
      ST_DONE  = 6'b100000
   } ils_state_type;

   ils_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_START;
            end
         end
         ST_START: begin
            if (stat.walk) state_in = ST_WALK;
            else if (stat.put) state_in = ST_PUT;
            else state_in = ST_DONE;
         end
         ST_WALK: begin
            cmd.rd = 1'b1;
            if (stat.last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = stat.put ? ST_PUT : ST_DONE;
         end
         ST_PUT: begin
            cmd.put  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   `ILS_ASSERT_NEXT(a_accept_starts, cmd.accept, state_ff == ST_START)
   `ILS_ASSERT_NEXT(a_walk_ends, state_ff == ST_WALK && stat.last, state_ff == ST_DRAIN)
   `ILS_ASSERT_NEXT(a_commit_shows, cmd.commit, rsp_valid_ff)

endmodule

// File: rtl/core/indexed_list_store.sv
// Top level of the indexed list store: stream ports, controller and datapath.
//
// Ordered store of up to CAPACITY (256) signed 32-bit values, one request
// word in and one response word out per operation. The store works on one
// request at a time: ready is high only while idle. After acceptance a
// request passes through the start state, walks n stored entries, drains
// the last read, places a new value for operations that add one, and then
// loads its response word; a request with nothing to walk goes from start
// straight to put or done. The walk goes through the entry memory (one
// read and one write port), one entry a cycle: n is the entries at and
// above the slot for insert and push, the entries above the slot for
// remove and pop, 1 for read, and the current count for search (zero for
// requests that fail). Ready returns in the same cycle that the response
// word is loaded. The response sits in an output register, so the next
// request is taken while the previous response still waits; that next
// request then holds in its final cycle until the earlier word is taken.
// No clearing pass follows reset: only slots below the count are ever
// read.
module indexed_list_store import ils_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // Request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [8:0] position, [40:9] item_value
   input  logic [ACT_W-1:0]      req_tuser,  // [2:0] action
   // Response stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // [31:0] read_value, [32] found,
                                             // [34:33] status, [43:35] entry_count
);

   ils_cmd_type  cmd;
   ils_stat_type stat;

   logic [POS_W-1:0] position;
   logic [VAL_W-1:0] item_value;

   // Unpack the request word; upper pad bits carry nothing.
   assign position   = req_tdata[POS_W-1:0];
   assign item_value = req_tdata[POS_W+VAL_W-1:POS_W];

   // Sequencer: owns the handshakes and steps the datapath.
   ils_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Entry memory, count, decode and response register.
   ils_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .action     (req_tuser),
      .position   (position),
      .item_value (item_value),
      .stat       (stat),
      .rsp_data   (rsp_tdata)
   );

endmodule
